/* hdl/ps2mpc_pkg.sv */
package ps2mpc_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 12;
   localparam int BTN_W     = 3;
   localparam int DELTA_W   = BYTE_W + 1;
   localparam int SUM_W     = POS_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam int SYNC_BIT  = 3;
   localparam int XSIGN_BIT = 4;
   localparam int YSIGN_BIT = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_X_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LIMIT = 2'd1;

   localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd1023;
   localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd767;
   localparam logic [POS_W-1:0] POS_X_RESET   = 12'd400;
   localparam logic [POS_W-1:0] POS_Y_RESET   = 12'd300;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_X_BYTE = 2'd1,
      PH_Y_BYTE = 2'd2
   } phase_type;

   typedef struct packed {
      logic               hit;
      logic [BTN_W-1:0]   buttons;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy_raw;
   } pkt_type;

endpackage

/* hdl/ps2mpc_ifs.sv */
interface ps2mpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2mpc_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ps2mpc_pkg::POS_W-1:0]   cursor_x;
   logic [ps2mpc_pkg::POS_W-1:0]   cursor_y;
   logic [ps2mpc_pkg::BTN_W-1:0]   button_bits;

   modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                   input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                   output ready);
endinterface

interface ps2mpc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ps2mpc_pkg::CSR_IDX_W-1:0]  index;
   logic [ps2mpc_pkg::POS_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ps2mpc_framer.sv */
module ps2mpc_framer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           byte_valid,
   input  logic [ps2mpc_pkg::BYTE_W-1:0]  byte_data,
   input  logic                           take,
   output ps2mpc_pkg::pkt_type            pkt
);

   ps2mpc_pkg::phase_type              phase_ff, phase_in;
   logic [ps2mpc_pkg::BYTE_W-1:0]      header_ff, header_in;
   logic [ps2mpc_pkg::BYTE_W-1:0]      xbyte_ff, xbyte_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ps2mpc_pkg::PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      xbyte_ff  <= xbyte_in;
   end

   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      xbyte_in    = xbyte_ff;
      pkt.hit     = 1'b0;
      pkt.buttons = header_ff[ps2mpc_pkg::BTN_W-1:0];
      pkt.dx      = {header_ff[ps2mpc_pkg::XSIGN_BIT], xbyte_ff};
      pkt.dy_raw  = {header_ff[ps2mpc_pkg::YSIGN_BIT], byte_data};
      unique case (phase_ff)
         ps2mpc_pkg::PH_X_BYTE: begin
            if (take) begin
               xbyte_in = byte_data;
               phase_in = ps2mpc_pkg::PH_Y_BYTE;
            end
         end
         ps2mpc_pkg::PH_Y_BYTE: begin
            pkt.hit = byte_valid;
            if (take) begin
               phase_in = ps2mpc_pkg::PH_HEADER;
            end
         end
         default: begin
            // drop a header without the sync bit
            if (take) begin
               if (byte_data[ps2mpc_pkg::SYNC_BIT]) begin
                  header_in = byte_data;
                  phase_in  = ps2mpc_pkg::PH_X_BYTE;
               end else begin
                  phase_in  = ps2mpc_pkg::PH_HEADER;
               end
            end
         end
      endcase
   end

endmodule

/* hdl/ps2mpc_cursor.sv */
module ps2mpc_cursor (
   input  logic                           clock,
   input  logic                           reset,
   input  ps2mpc_pkg::pkt_type            pkt,
   input  logic                           load,
   input  logic [ps2mpc_pkg::POS_W-1:0]   x_limit,
   input  logic [ps2mpc_pkg::POS_W-1:0]   y_limit,
   output logic                           slot_free,
   ps2mpc_rsp_if.source                   rsp_chan
);

   localparam int EXT_W = ps2mpc_pkg::SUM_W - ps2mpc_pkg::DELTA_W;

   logic [ps2mpc_pkg::POS_W-1:0]  pos_x_ff, pos_x_in;
   logic [ps2mpc_pkg::POS_W-1:0]  pos_y_ff, pos_y_in;
   logic [ps2mpc_pkg::BTN_W-1:0]  btn_ff, btn_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ps2mpc_pkg::SUM_W-1:0]  x_sum;
   logic [ps2mpc_pkg::SUM_W-1:0]  y_sum;

   function automatic logic [ps2mpc_pkg::POS_W-1:0] clamp_axis(
      input logic [ps2mpc_pkg::SUM_W-1:0] sum,
      input logic [ps2mpc_pkg::POS_W-1:0] limit
   );
      logic [ps2mpc_pkg::POS_W-1:0] res;
      if (sum[ps2mpc_pkg::SUM_W-1]) begin
         res = '0;
      end else if (sum[ps2mpc_pkg::SUM_W-2:0] > {1'b0, limit}) begin
         res = limit;
      end else begin
         res = sum[ps2mpc_pkg::POS_W-1:0];
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= ps2mpc_pkg::POS_X_RESET;
         pos_y_ff     <= ps2mpc_pkg::POS_Y_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      btn_ff <= btn_in;
   end

   always_comb begin
      // screen-down is positive, so subtract the Y delta
      x_sum = {2'b00, pos_x_ff} + {{EXT_W{pkt.dx[ps2mpc_pkg::DELTA_W-1]}}, pkt.dx};
      y_sum = {2'b00, pos_y_ff} - {{EXT_W{pkt.dy_raw[ps2mpc_pkg::DELTA_W-1]}}, pkt.dy_raw};
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      btn_in       = btn_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         pos_x_in     = clamp_axis(x_sum, x_limit);
         pos_y_in     = clamp_axis(y_sum, y_limit);
         btn_in       = pkt.buttons;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign slot_free            = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cursor_x    = pos_x_ff;
   assign rsp_chan.cursor_y    = pos_y_ff;
   assign rsp_chan.button_bits = btn_ff;

endmodule

/* hdl/ps2_mouse_packet_cursor.sv */
// Channel   Dir  Payload                               Accepted when
// req_chan  in   rx_byte[7:0]                          valid && ready
// rsp_chan  out  cursor_x[11:0] cursor_y[11:0] button_bits[2:0]  valid && ready
// csr_chan  in   index[1:0] data[11:0]                 valid && ready (ready always high)
//
// One byte per cycle sustained unless the input register stalls; the result register loads
// while the third byte sits in the input register and passes the framer and clamp adders,
// so that byte passes the input register and then the result register before it is valid.
// The input register stalls only when it holds a third byte and the result register
// is full and not being taken. Reset clears the framing phase and the result valid,
// and sets the limits to 1023/767 and the cursor to 400/300.
module ps2_mouse_packet_cursor (
   input  logic          clock,
   input  logic          reset,
   ps2mpc_req_if.sink    req_chan,
   ps2mpc_rsp_if.source  rsp_chan,
   ps2mpc_csr_if.sink    csr_chan
);

   logic                           s1_valid_ff, s1_valid_in;
   logic [ps2mpc_pkg::BYTE_W-1:0]  s1_byte_ff, s1_byte_in;
   logic [ps2mpc_pkg::POS_W-1:0]   x_limit_ff, x_limit_in;
   logic [ps2mpc_pkg::POS_W-1:0]   y_limit_ff, y_limit_in;
   ps2mpc_pkg::pkt_type            pkt;
   logic                           slot_free;
   logic                           advance;
   logic                           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         x_limit_ff  <= ps2mpc_pkg::X_LIMIT_RESET;
         y_limit_ff  <= ps2mpc_pkg::Y_LIMIT_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         x_limit_ff  <= x_limit_in;
         y_limit_ff  <= y_limit_in;
      end
      s1_byte_ff <= s1_byte_in;
   end

   assign advance          = s1_valid_ff && (!pkt.hit || slot_free);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign accept           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ps2mpc_pkg::CSR_X_LIMIT: x_limit_in = csr_chan.data;
            ps2mpc_pkg::CSR_Y_LIMIT: y_limit_in = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   ps2mpc_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (s1_valid_ff),
      .byte_data  (s1_byte_ff),
      .take       (advance),
      .pkt        (pkt)
   );

   ps2mpc_cursor u_cursor (
      .clock     (clock),
      .reset     (reset),
      .pkt       (pkt),
      .load      (advance && pkt.hit),
      .x_limit   (x_limit_ff),
      .y_limit   (y_limit_ff),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* hdl/ps2mpc_checker.sv */
module ps2mpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ps2mpc_pkg::POS_W-1:0]   cursor_x,
   input logic [ps2mpc_pkg::POS_W-1:0]   cursor_y,
   input logic [ps2mpc_pkg::BTN_W-1:0]   button_bits,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [ps2mpc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ps2mpc_pkg::POS_W-1:0]   csr_data
);

   logic [1:0]                    seen_ff, seen_in;
   logic [ps2mpc_pkg::POS_W-1:0]  xlim_ff, xlim_in;
   logic [ps2mpc_pkg::POS_W-1:0]  ylim_ff, ylim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         xlim_ff <= ps2mpc_pkg::X_LIMIT_RESET;
         ylim_ff <= ps2mpc_pkg::Y_LIMIT_RESET;
      end else begin
         seen_ff <= seen_in;
         xlim_ff <= xlim_in;
         ylim_ff <= ylim_in;
      end
   end

   always_comb begin
      seen_in = seen_ff;
      xlim_in = xlim_ff;
      ylim_in = ylim_ff;
      if (req_valid && req_ready && seen_ff != 2'd3) begin
         seen_in = seen_ff + 2'd1;
      end
      if (csr_valid && csr_ready) begin
         if (csr_index == ps2mpc_pkg::CSR_X_LIMIT) begin
            xlim_in = csr_data;
         end
         if (csr_index == ps2mpc_pkg::CSR_Y_LIMIT) begin
            ylim_in = csr_data;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_x) && $stable(cursor_y)
         && $stable(button_bits))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_needs_packet: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(seen_ff) == 2'd3)
      else $error("result before three bytes were taken");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> cursor_x <= $past(xlim_ff) && cursor_y <= $past(ylim_ff))
      else $error("cursor outside its limits");

endmodule

bind ps2_mouse_packet_cursor ps2mpc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .cursor_x    (rsp_chan.cursor_x),
   .cursor_y    (rsp_chan.cursor_y),
   .button_bits (rsp_chan.button_bits),
   .csr_valid   (csr_chan.valid),
   .csr_ready   (csr_chan.ready),
   .csr_index   (csr_chan.index),
   .csr_data    (csr_chan.data)
);
